### design/lpsa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the linear probe slot allocator
// no dependencies; imported by linear_probe_slot_allocator

package lpsa_pkg;

    // number of slots in the table; must be a power of two (fold and wrap are masks)
    localparam int unsigned TABLE_SLOTS = 1024;
    localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);

    // widths of the word fields
    localparam int unsigned KEY_W      = 8;
    localparam int unsigned SLOT_OUT_W = 10;
    localparam int unsigned OUT_DATA_W = 16;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TEST
    } lpsa_state_t;

endpackage

### design/linear_probe_slot_allocator.sv
`timescale 1ns / 1ps
// linear probe slot allocator: folds key bytes into a home index and probes an occupancy map
// depends on lpsa_pkg

// Keys arrive one byte per word on the slave side; the byte with tlast set closes the key.
// A byte without tlast is folded into the home index and gives no result.
// A closing byte starts a probe walk over the occupancy map, one slot per cycle through a
// single read port, from the home slot forward with wraparound, trying 1 to TABLE_SLOTS
// slots. The first free slot is marked and its number returned; after a full sweep without
// a free slot the table_full flag is returned and nothing is marked. The walk holds on its
// last probe while an earlier result waits to be taken. After reset the map is cleared by a
// pass over all TABLE_SLOTS slots (1024), during which no byte is accepted.

module linear_probe_slot_allocator
    import lpsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEY_W-1:0]      s_tdata,   // [7:0] key_byte
    input  logic                  s_tlast,   // last_byte
    // master side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [9:0] slot_index, [15:10] zero
    output logic                  m_tuser    // [0] table_full
);

    // occupancy map
    logic occ_mem [TABLE_SLOTS];

    lpsa_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] running_reg, running_next;
    logic [SLOT_W-1:0] probe_reg, probe_next;
    logic [SLOT_W-1:0] tries_reg, tries_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic              full_reg;
    logic              occ_rd_reg;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    logic              load_out;
    logic              load_full;
    logic              in_accept;
    logic              out_free;

    logic [SLOT_W+KEY_W-1:0]      fold_wide;
    logic [SLOT_W-1:0]            fold_index;
    logic [SLOT_W+SLOT_OUT_W-1:0] probe_ext;

    // fold: (index * 256 + byte) mod TABLE_SLOTS, a shift and a mask
    assign fold_wide  = {running_reg, s_tdata};
    assign fold_index = fold_wide[SLOT_W-1:0];
    assign probe_ext  = {{SLOT_OUT_W{1'b0}}, probe_reg};

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        probe_next     = probe_reg;
        tries_next     = tries_reg;
        clr_cnt_next   = clr_cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = probe_reg;
        mem_wdata      = 1'b1;
        mem_raddr      = probe_reg;
        load_out       = 1'b0;
        load_full      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tlast)
                    begin
                        running_next = '0;
                        probe_next   = fold_index;
                        mem_raddr    = fold_index;
                        tries_next   = '0;
                        state_next   = ST_TEST;
                    end
                    else
                    begin
                        running_next = fold_index;
                    end
                end
            end
            ST_TEST:
            begin
                if (!occ_rd_reg)
                begin
                    // free slot: claim it once the output register is free
                    if (out_free)
                    begin
                        mem_we     = 1'b1;
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (tries_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    // full sweep done with no free slot
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        load_full  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    mem_raddr  = probe_reg + 1'b1;
                    tries_next = tries_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            running_reg   <= '0;
            probe_reg     <= '0;
            tries_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            probe_reg     <= probe_next;
            tries_reg     <= tries_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            full_reg <= load_full;
            slot_reg <= load_full ? '0 : probe_ext[SLOT_OUT_W-1:0];
        end
    end

    // occupancy map write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        occ_rd_reg <= occ_mem[mem_raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-SLOT_OUT_W){1'b0}}, slot_reg};
    assign m_tuser  = full_reg;

    // a slot is marked only after it was read as free
    a_mark_free_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST && mem_we) |-> !occ_rd_reg)
        else $error("slot marked while read as occupied");

    // marking a slot always loads a result
    a_mark_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST && mem_we) |=> (m_tvalid && !m_tuser))
        else $error("slot marked without a result");

    // a closing byte starts a probe walk with a cleared running index
    a_last_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_TEST && running_reg == '0))
        else $error("closing byte did not start a probe walk");

    // a new result only comes from the end of a probe walk
    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_TEST))
        else $error("result appeared outside a probe walk");

    // table full never marks a slot
    a_full_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
        load_full |-> !mem_we)
        else $error("slot marked on a full table");

endmodule
